FILE: rtl/tslr_pkg.sv
// Shared types and constants for the text and sprite line renderer.
`timescale 1ns / 1ps
`default_nettype none

package tslr_pkg;

  localparam int unsigned GLYPH_ROWS  = 8;
  localparam int unsigned GLYPH_DEPTH = 2048;
  localparam int unsigned GLYPH_AW    = 11;
  localparam int unsigned MAX_COL_W   = 6;   // up to 64 text columns
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = 2;

  typedef enum logic [2:0] {
    CMD_WR_CELL  = 3'd0,
    CMD_WR_GLYPH = 3'd1,
    CMD_WR_ATTR  = 3'd2,
    CMD_WR_ROW   = 3'd3,
    CMD_RENDER   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPRITE,
    ST_TEXT
  } state_t;

  typedef struct packed {
    logic       attr_we;
    logic       row_we;
    logic [3:0] index;
    logic [2:0] prow;
    logic [8:0] x;
    logic [7:0] y;
    logic       enable;
    logic [7:0] data;
  } spr_wr_t;

  typedef struct packed {
    logic                 start;
    logic [7:0]           line;
    logic                 rd_en;
    logic [MAX_COL_W-1:0] rd_col;
  } ovl_ctrl_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [4:0] column;
    logic       last;
  } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/tslr_if.sv
// Valid/ready channel interfaces for the command input and the pixel output.
`timescale 1ns / 1ps
`default_nettype none

interface tslr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [10:0] address;
  logic [7:0] data;
  logic [3:0] sprite_index;
  logic [2:0] pattern_row;
  logic [8:0] sprite_x;
  logic [7:0] sprite_y;
  logic       sprite_enable;
  logic [7:0] line;

  modport source (
    output valid, command, address, data, sprite_index, pattern_row,
           sprite_x, sprite_y, sprite_enable, line,
    input  ready
  );
  modport sink (
    input  valid, command, address, data, sprite_index, pattern_row,
           sprite_x, sprite_y, sprite_enable, line,
    output ready
  );
endinterface

interface tslr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic [4:0] column;
  logic       last;

  modport source (output valid, pixel_byte, column, last, input ready);
  modport sink (input valid, pixel_byte, column, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/tslr_sprite_unit.sv
// Sprite table, pattern memory and the banked overlay line buffer.
`timescale 1ns / 1ps
`default_nettype none

module tslr_sprite_unit
  import tslr_pkg::*;
#(
  parameter int unsigned TEXT_COLUMNS = 32,
  parameter int unsigned SPRITE_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  spr_wr_t    wr_i,
  input  ovl_ctrl_t  ctrl_i,
  output logic       busy_o,
  output logic [7:0] rd_data_o
);

  localparam int unsigned HALF      = (TEXT_COLUMNS + 1) / 2;
  localparam int unsigned HW        = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned SW        = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int unsigned BMP_DEPTH = SPRITE_COUNT * GLYPH_ROWS;
  localparam int unsigned BW        = SW + 3;

  // attribute table
  logic [8:0]              spr_x_r [SPRITE_COUNT];
  logic [7:0]              spr_y_r [SPRITE_COUNT];
  logic [SPRITE_COUNT-1:0] spr_on_r;

  logic [4:0]    idx_ext;
  logic [SW-1:0] wr_idx;
  logic          idx_ok;

  assign idx_ext = 5'(wr_i.index);
  assign wr_idx  = idx_ext[SW-1:0];
  assign idx_ok  = 6'(wr_i.index) < 6'(SPRITE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_on_r <= '0;
    end else if (wr_i.attr_we && idx_ok) begin
      spr_on_r[wr_idx] <= wr_i.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.attr_we && idx_ok) begin
      spr_x_r[wr_idx] <= wr_i.x;
      spr_y_r[wr_idx] <= wr_i.y;
    end
  end

  // sprite walk control
  logic          run_r;
  logic [SW-1:0] s_r;
  logic [7:0]    line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      s_r   <= '0;
    end else if (ctrl_i.start) begin
      run_r <= 1'b1;
      s_r   <= '0;
    end else if (run_r) begin
      s_r <= s_r + 1'b1;
      if (s_r == SW'(SPRITE_COUNT - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.start) begin
      line_r <= ctrl_i.line;
    end
  end

  // clearing pass over the overlay after reset
  logic          clr_act_r;
  logic [HW-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_act_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == HW'(HALF - 1)) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  // stage 0: coverage test and pattern read
  logic [7:0]    s0_top;
  logic [8:0]    s0_ln9;
  logic [8:0]    s0_top9;
  logic          s0_hit;
  logic [2:0]    s0_rowoff;
  logic [BW-1:0] bmp_raddr;
  logic [BW-1:0] bmp_waddr;
  logic          bmp_we;
  logic [7:0]    bmp_mem [BMP_DEPTH];
  logic [7:0]    bmp_rd_r;

  assign s0_top    = spr_y_r[s_r];
  assign s0_ln9    = {1'b0, line_r};
  assign s0_top9   = {1'b0, s0_top};
  assign s0_hit    = run_r && spr_on_r[s_r] && (s0_ln9 >= s0_top9) &&
                     (s0_ln9 < s0_top9 + 9'(GLYPH_ROWS));
  assign s0_rowoff = 3'(line_r - s0_top);
  assign bmp_raddr = {s_r, s0_rowoff};
  assign bmp_waddr = {wr_idx, wr_i.prow};
  assign bmp_we    = wr_i.row_we && idx_ok;

  always_ff @(posedge clk) begin
    if (bmp_we) begin
      bmp_mem[bmp_waddr] <= wr_i.data;
    end
    bmp_rd_r <= bmp_mem[bmp_raddr];
  end

  logic       p1_hit_r;
  logic       p1_occ_r;
  logic [8:0] p1_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_hit_r <= 1'b0;
      p1_occ_r <= 1'b0;
    end else begin
      p1_hit_r <= s0_hit;
      p1_occ_r <= run_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_x_r <= spr_x_r[s_r];
  end

  // stage 1: split the pattern row over two columns, read both banks
  logic [5:0]             cx;
  logic [2:0]             sx;
  logic [6:0]             cx1;
  logic [7:0]             lo_byte;
  logic [15:0]            hi_wide;
  logic [7:0]             hi_byte;
  logic                   lo_ok;
  logic                   hi_ok;
  logic [HW-1:0]          lo_idx;
  logic [HW-1:0]          hi_idx;
  logic [1:0]             s1_en;
  logic [1:0][HW-1:0]     s1_idx;
  logic [1:0][7:0]        s1_dat;

  assign cx      = p1_x_r[8:3];
  assign sx      = p1_x_r[2:0];
  assign cx1     = 7'(cx) + 7'd1;
  assign lo_byte = bmp_rd_r >> sx;
  assign hi_wide = {bmp_rd_r, 8'h00} >> sx;
  assign hi_byte = hi_wide[7:0];
  assign lo_ok   = p1_hit_r && (7'(cx) < 7'(TEXT_COLUMNS));
  assign hi_ok   = p1_hit_r && (sx != 3'd0) && (cx1 < 7'(TEXT_COLUMNS));
  assign lo_idx  = HW'(cx >> 1);
  assign hi_idx  = HW'(cx1 >> 1);

  // even columns live in bank 0, odd columns in bank 1
  always_comb begin
    if (cx[0]) begin
      s1_en  = {lo_ok, hi_ok};
      s1_idx = {lo_idx, hi_idx};
      s1_dat = {lo_byte, hi_byte};
    end else begin
      s1_en  = {hi_ok, lo_ok};
      s1_idx = {hi_idx, lo_idx};
      s1_dat = {hi_byte, lo_byte};
    end
  end

  logic [1:0]         p2_en_r;
  logic               p2_occ_r;
  logic [1:0][HW-1:0] p2_idx_r;
  logic [1:0][7:0]    p2_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_en_r  <= '0;
      p2_occ_r <= 1'b0;
    end else begin
      p2_en_r  <= s1_en;
      p2_occ_r <= p1_occ_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_idx_r <= s1_idx;
    p2_dat_r <= s1_dat;
  end

  // stage 2: merge and write back, forward the previous write
  logic [7:0]         ov_mem [2][HALF];
  logic [1:0][7:0]    ov_rd_r;
  logic [1:0]         ov_we;
  logic [1:0][HW-1:0] ov_wa;
  logic [1:0][7:0]    ov_wd;
  logic [1:0][HW-1:0] ov_ra;
  logic [1:0][7:0]    merged;
  logic [1:0]         w_en_r;
  logic [1:0][HW-1:0] w_idx_r;
  logic [1:0][7:0]    w_val_r;
  logic [HW-1:0]      rd_idx;
  logic               rd_bank;
  logic               rd_bank_r;

  assign rd_idx  = HW'(ctrl_i.rd_col >> 1);
  assign rd_bank = ctrl_i.rd_col[0];

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      if (w_en_r[b] && (w_idx_r[b] == p2_idx_r[b])) begin
        merged[b] = w_val_r[b] | p2_dat_r[b];
      end else begin
        merged[b] = ov_rd_r[b] | p2_dat_r[b];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      ov_ra[b] = ctrl_i.rd_en ? rd_idx : s1_idx[b];
      if (clr_act_r) begin
        ov_we[b] = 1'b1;
        ov_wa[b] = clr_idx_r;
        ov_wd[b] = 8'h00;
      end else if (p2_en_r[b]) begin
        ov_we[b] = 1'b1;
        ov_wa[b] = p2_idx_r[b];
        ov_wd[b] = merged[b];
      end else if (ctrl_i.rd_en && (rd_bank == 1'(b))) begin
        // read and clear, so the buffer is blank for the next line
        ov_we[b] = 1'b1;
        ov_wa[b] = rd_idx;
        ov_wd[b] = 8'h00;
      end else begin
        ov_we[b] = 1'b0;
        ov_wa[b] = rd_idx;
        ov_wd[b] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 2; b++) begin
      if (ov_we[b]) begin
        ov_mem[b][ov_wa[b]] <= ov_wd[b];
      end
      ov_rd_r[b] <= ov_mem[b][ov_ra[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_en_r <= '0;
    end else begin
      w_en_r <= p2_en_r;
    end
  end

  always_ff @(posedge clk) begin
    w_idx_r   <= p2_idx_r;
    w_val_r   <= merged;
    rd_bank_r <= rd_bank;
  end

  assign rd_data_o = ov_rd_r[rd_bank_r];
  assign busy_o    = clr_act_r | run_r | p1_occ_r | p2_occ_r;

endmodule

`default_nettype wire

FILE: rtl/text_sprite_line_renderer.sv
// Top level: command decode, character and glyph memories, text pass, output buffer.
// Use: commands enter on in_port (valid/ready). Write-cell, write-glyph, write-sprite
// attribute and write-sprite-row commands return nothing.
// A render command returns TEXT_COLUMNS words on out_port (valid/ready), columns in
// order, last set on the final one.
// A render runs in two passes. The sprite pass walks the sprite table one entry a
// cycle and ORs each covering pattern row into a two-bank overlay buffer. The text
// pass then issues one column a cycle, while the output buffer has room, through the
// cell memory, the glyph memory and the overlay read. in_port.ready is low for the
// whole render, then high again.
// Reset: a clearing pass blanks the overlay buffer, with in_port.ready low. Cell,
// glyph and pattern memories are not cleared.
// Stall: a four-word output buffer holds finished words; the text pass issues a
// column only when the buffer has room, so nothing is lost while out_port waits.
`timescale 1ns / 1ps
`default_nettype none

module text_sprite_line_renderer
  import tslr_pkg::*;
#(
  parameter int unsigned TEXT_COLUMNS = 32,
  parameter int unsigned TEXT_ROWS    = 24,
  parameter int unsigned SPRITE_COUNT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  tslr_in_if.sink        in_port,
  tslr_out_if.source     out_port
);

  localparam int unsigned CELLS   = TEXT_COLUMNS * TEXT_ROWS;
  localparam int unsigned CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CNT_W   = $clog2(TEXT_COLUMNS + 1);

  state_t st_r;
  state_t st_nxt;

  logic in_ready;
  logic text_run;
  logic in_acc;
  logic is_render;
  logic ovl_busy;
  logic text_done;

  assign in_acc    = in_port.valid && in_ready;
  assign is_render = in_port.command == CMD_RENDER;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:  if (!ovl_busy) st_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc && is_render) st_nxt = ST_SPRITE;
      ST_SPRITE: if (!ovl_busy) st_nxt = ST_TEXT;
      ST_TEXT:   if (text_done) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    text_run = 1'b0;
    unique case (st_r)
      ST_CLEAR:  ;
      ST_IDLE:   in_ready = 1'b1;
      ST_SPRITE: ;
      ST_TEXT:   text_run = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_port.ready = in_ready;

  // character and glyph memories
  logic [7:0]          cell_mem [CELLS];
  logic [7:0]          glyph_mem [GLYPH_DEPTH];
  logic [7:0]          cell_rd_r;
  logic [7:0]          glyph_rd_r;
  logic                cell_we;
  logic                glyph_we;
  logic [CELL_AW-1:0]  cell_waddr;
  logic [CELL_AW-1:0]  cell_raddr;
  logic [GLYPH_AW-1:0] glyph_raddr;

  logic [CNT_W-1:0]   col_r;
  logic [CELL_AW-1:0] row_base_r;
  logic [2:0]         sy_r;
  logic               text_on_r;
  logic [11:0]        base_full;

  assign cell_we    = in_acc && (in_port.command == CMD_WR_CELL) &&
                      ({1'b0, in_port.address} < 12'(CELLS));
  assign glyph_we   = in_acc && (in_port.command == CMD_WR_GLYPH);
  assign cell_waddr = in_port.address[CELL_AW-1:0];
  assign cell_raddr = row_base_r + CELL_AW'(col_r);
  assign glyph_raddr = {cell_rd_r, sy_r};
  assign base_full  = 12'(in_port.line[7:3]) * 12'(TEXT_COLUMNS);

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= in_port.data;
    end
    cell_rd_r <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[in_port.address] <= in_port.data;
    end
    glyph_rd_r <= glyph_mem[glyph_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_render) begin
      row_base_r <= base_full[CELL_AW-1:0];
      sy_r       <= in_port.line[2:0];
      text_on_r  <= 6'(in_port.line[7:3]) < 6'(TEXT_ROWS);
    end
  end

  // text pass: issue a column when the output buffer has room for it
  logic                t1_vld_r;
  logic                t2_vld_r;
  logic [CNT_W-1:0]    t1_col_r;
  logic [CNT_W-1:0]    t2_col_r;
  logic [FIFO_AW:0]    fifo_cnt_r;
  logic                issue;
  logic [2:0]          in_flight;

  assign in_flight = 3'(fifo_cnt_r) + 3'(t1_vld_r) + 3'(t2_vld_r);
  assign issue     = text_run && (col_r < CNT_W'(TEXT_COLUMNS)) &&
                     (in_flight < 3'(FIFO_DEPTH));
  assign text_done = (col_r == CNT_W'(TEXT_COLUMNS)) && !t1_vld_r && !t2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
    end else begin
      if (in_acc && is_render) begin
        col_r <= '0;
      end else if (issue) begin
        col_r <= col_r + 1'b1;
      end
      t1_vld_r <= issue;
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_col_r <= col_r;
    t2_col_r <= t1_col_r;
  end

  // sprite unit
  spr_wr_t    spr_wr;
  ovl_ctrl_t  ovl_ctrl;
  logic [7:0] ovl_byte;

  always_comb begin
    spr_wr.attr_we = in_acc && (in_port.command == CMD_WR_ATTR);
    spr_wr.row_we  = in_acc && (in_port.command == CMD_WR_ROW);
    spr_wr.index   = in_port.sprite_index;
    spr_wr.prow    = in_port.pattern_row;
    spr_wr.x       = in_port.sprite_x;
    spr_wr.y       = in_port.sprite_y;
    spr_wr.enable  = in_port.sprite_enable;
    spr_wr.data    = in_port.data;
  end

  always_comb begin
    ovl_ctrl.start  = in_acc && is_render;
    ovl_ctrl.line   = in_port.line;
    ovl_ctrl.rd_en  = t1_vld_r;
    ovl_ctrl.rd_col = MAX_COL_W'(t1_col_r);
  end

  tslr_sprite_unit #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .SPRITE_COUNT (SPRITE_COUNT)
  ) u_sprite (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (spr_wr),
    .ctrl_i    (ovl_ctrl),
    .busy_o    (ovl_busy),
    .rd_data_o (ovl_byte)
  );

  // output buffer
  out_word_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  out_word_t            push_word;
  logic [6:0]           col_ext;
  logic                 pop;

  assign col_ext = 7'(t2_col_r);

  always_comb begin
    push_word.pixel_byte = (text_on_r ? glyph_rd_r : 8'h00) | ovl_byte;
    push_word.column     = col_ext[4:0];
    push_word.last       = t2_col_r == CNT_W'(TEXT_COLUMNS - 1);
  end

  assign pop = out_port.valid && out_port.ready;

  always_ff @(posedge clk) begin
    if (t2_vld_r) begin
      fifo_mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (t2_vld_r) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + (FIFO_AW + 1)'(t2_vld_r) - (FIFO_AW + 1)'(pop);
    end
  end

  assign out_port.valid      = fifo_cnt_r != '0;
  assign out_port.pixel_byte = fifo_mem[rd_ptr_r].pixel_byte;
  assign out_port.column     = fifo_mem[rd_ptr_r].column;
  assign out_port.last       = fifo_mem[rd_ptr_r].last;

endmodule

`default_nettype wire

FILE: rtl/tslr_checker.sv
// Port-level checks on the line renderer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tslr_checker
  import tslr_pkg::*;
#(
  parameter int unsigned TEXT_COLUMNS = 32
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_command,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_pixel_byte,
  input wire logic [4:0] out_column,
  input wire logic       out_last
);

  logic       in_acc;
  logic       out_acc;
  logic       render_acc;
  logic [6:0] word_cnt_r;
  logic [7:0] pend_r;

  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign render_acc = in_acc && (in_command == CMD_RENDER);

  // track position within the line and words still owed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      if (out_acc) begin
        word_cnt_r <= out_last ? 7'd0 : word_cnt_r + 7'd1;
      end
      pend_r <= pend_r + (render_acc ? 8'(TEXT_COLUMNS) : 8'd0) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_byte) &&
      $stable(out_column) && $stable(out_last))
    else $error("stalled output word changed");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (out_column == word_cnt_r[4:0]) &&
      (out_last == (word_cnt_r == 7'(TEXT_COLUMNS - 1))))
    else $error("output column or last out of sequence");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("output word without a pending render");

  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    render_acc |=> !in_ready)
    else $error("input ready right after a render command");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind text_sprite_line_renderer tslr_checker #(
  .TEXT_COLUMNS (TEXT_COLUMNS)
) u_tslr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_port.valid),
  .in_ready       (in_port.ready),
  .in_command     (in_port.command),
  .out_valid      (out_port.valid),
  .out_ready      (out_port.ready),
  .out_pixel_byte (out_port.pixel_byte),
  .out_column     (out_port.column),
  .out_last       (out_port.last)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the text and sprite line renderer.
`timescale 1ns / 1ps

module tb_top;
  import tslr_pkg::*;

  localparam int unsigned TEXT_COLUMNS = 32;
  localparam int unsigned TEXT_ROWS    = 24;
  localparam int unsigned SPRITE_COUNT = 16;
  localparam int unsigned CELL_COUNT   = TEXT_COLUMNS * TEXT_ROWS;
  localparam int unsigned BITMAP_DEPTH = SPRITE_COUNT * GLYPH_ROWS;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned RANDOM_WORDS = 80;
  localparam int unsigned CALM_FIRST   = 25;
  localparam int unsigned CALM_LAST    = 55;
  localparam int unsigned GLYPH_CODES  = 2;
  localparam int unsigned READY_SPRITES = 3;
  localparam int unsigned RENDER_TRIES = 32;
  localparam int unsigned DRAIN_CYCLES = 2 * (SPRITE_COUNT + TEXT_COLUMNS + 7);
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [10:0] address;
    logic [7:0]  data;
    logic [3:0]  sprite_index;
    logic [2:0]  pattern_row;
    logic [8:0]  sprite_x;
    logic [7:0]  sprite_y;
    logic        sprite_enable;
    logic [7:0]  line;
  } cmd_word_t;

  typedef struct packed {
    cmd_word_t  word;
    logic       typed;
    logic [7:0] fill;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Shadow copy of the renderer's stores
  logic [7:0] char_map [CELL_COUNT];
  logic [7:0] glyph_rom [GLYPH_DEPTH];
  logic [8:0] sprite_left [SPRITE_COUNT];
  logic [7:0] sprite_top [SPRITE_COUNT];
  logic       sprite_on [SPRITE_COUNT];
  logic [7:0] sprite_pattern [BITMAP_DEPTH];

  // Entries written so far; renders only read these
  bit cell_known [CELL_COUNT];
  bit glyph_known [GLYPH_DEPTH];
  bit pattern_known [BITMAP_DEPTH];

  out_word_t   pending_pixels [$];
  script_row_t script [$];

  tslr_in_if  in_bus ();
  tslr_out_if out_bus ();

  text_sprite_line_renderer #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .SPRITE_COUNT (SPRITE_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_bus),
    .out_port (out_bus)
  );

  always begin
    #5;
    clk = 1'b1;
    #5;
    clk = 1'b0;
  end

  function automatic cmd_word_t noisy_word();
    cmd_word_t w;
    w.command       = CMD_WR_CELL;
    w.address       = 11'($urandom);
    w.data          = 8'($urandom);
    w.sprite_index  = 4'($urandom);
    w.pattern_row   = 3'($urandom);
    w.sprite_x      = 9'($urandom);
    w.sprite_y      = 8'($urandom);
    w.sprite_enable = 1'($urandom);
    w.line          = 8'($urandom);
    return w;
  endfunction

  function automatic bit sprite_ready(logic [3:0] idx);
    bit ok;
    ok = 1'b1;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (!pattern_known[idx * GLYPH_ROWS + r]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // True when a render of this line touches only written entries
  function automatic bit render_safe(logic [7:0] ln);
    int unsigned text_row;
    int unsigned top;
    logic [7:0]  code;
    bit          ok;
    text_row = ln / GLYPH_ROWS;
    ok = 1'b1;
    if (text_row < TEXT_ROWS) begin
      for (int c = 0; c < TEXT_COLUMNS; c++) begin
        if (!cell_known[text_row * TEXT_COLUMNS + c]) begin
          ok = 1'b0;
        end else begin
          code = char_map[text_row * TEXT_COLUMNS + c];
          if (!glyph_known[{code, ln[2:0]}]) begin
            ok = 1'b0;
          end
        end
      end
    end
    for (int s = 0; s < SPRITE_COUNT; s++) begin
      top = sprite_top[s];
      if (sprite_on[s] && ln >= top && ln < top + GLYPH_ROWS) begin
        if (!pattern_known[s * GLYPH_ROWS + (ln - top)]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t   w;
    int unsigned pick;
    int unsigned k;
    logic [7:0]  cand;
    bit          found;
    w = noisy_word();
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      w.command = CMD_WR_CELL;
      w.data    = 8'($urandom_range(0, GLYPH_CODES - 1));
      if ($urandom_range(0, 9) == 0) begin
        w.address = 11'($urandom_range(CELL_COUNT, GLYPH_DEPTH - 1));
      end else if ($urandom_range(0, 1) == 0) begin
        w.address = 11'($urandom_range(0, TEXT_COLUMNS - 1));
      end else begin
        w.address = 11'((TEXT_ROWS - 1) * TEXT_COLUMNS +
                        $urandom_range(0, TEXT_COLUMNS - 1));
      end
    end else if (pick < 40) begin
      w.command = CMD_WR_GLYPH;
      // mostly repaint the glyphs in use
      if ($urandom_range(0, 3) != 0) begin
        w.address = 11'($urandom_range(0, GLYPH_CODES * GLYPH_ROWS - 1));
      end
    end else if (pick < 55) begin
      w.command = CMD_WR_ATTR;
      // keep most sprites on screen and shown
      if ($urandom_range(0, 4) != 0) begin
        w.sprite_x[8] = 1'b0;
      end
      w.sprite_enable = sprite_ready(w.sprite_index) && ($urandom_range(0, 3) != 0);
    end else if (pick < 68) begin
      w.command = CMD_WR_ROW;
    end else if (pick < 96) begin
      w.command = CMD_RENDER;
      found = 1'b0;
      for (int t = 0; t < RENDER_TRIES && !found; t++) begin
        cand = 8'($urandom);
        // aim half the renders at a sprite's rows; wraps past 255 on purpose
        if (t == 0 && $urandom_range(0, 1) != 0) begin
          k = $urandom_range(0, SPRITE_COUNT - 1);
          cand = sprite_top[k] + 8'($urandom_range(0, GLYPH_ROWS - 1));
        end
        if (render_safe(cand)) begin
          w.line = cand;
          found  = 1'b1;
        end
      end
      if (!found) begin
        w.command = CMD_WR_GLYPH;
      end
    end else begin
      w.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end
    return w;
  endfunction

  function automatic script_row_t plan_step(logic [2:0] cmd, int unsigned addr,
                                            logic [7:0] data, int unsigned idx,
                                            int unsigned prow, int unsigned x,
                                            int unsigned y, logic en, int unsigned ln,
                                            logic typed, logic [7:0] fill);
    script_row_t r;
    r.word.command       = cmd;
    r.word.address       = 11'(addr);
    r.word.data          = data;
    r.word.sprite_index  = 4'(idx);
    r.word.pattern_row   = 3'(prow);
    r.word.sprite_x      = 9'(x);
    r.word.sprite_y      = 8'(y);
    r.word.sprite_enable = en;
    r.word.line          = 8'(ln);
    r.typed              = typed;
    r.fill               = fill;
    return r;
  endfunction

  // Update the shadow stores and queue the bytes a render should produce
  function automatic void predict_pixels(cmd_word_t w, logic typed, logic [7:0] fill);
    logic [7:0]  row_bytes [TEXT_COLUMNS];
    logic [2:0]  glyph_line;
    logic [7:0]  pat;
    int unsigned text_row;
    int unsigned top;
    int unsigned cx;
    int unsigned sx;
    out_word_t   want;
    case (w.command)
      CMD_WR_CELL: begin
        if (w.address < CELL_COUNT) begin
          char_map[w.address]   = w.data;
          cell_known[w.address] = 1'b1;
        end
      end
      CMD_WR_GLYPH: begin
        glyph_rom[w.address]   = w.data;
        glyph_known[w.address] = 1'b1;
      end
      CMD_WR_ATTR: begin
        if (w.sprite_index < SPRITE_COUNT) begin
          sprite_left[w.sprite_index] = w.sprite_x;
          sprite_top[w.sprite_index]  = w.sprite_y;
          sprite_on[w.sprite_index]   = w.sprite_enable;
        end
      end
      CMD_WR_ROW: begin
        if (w.sprite_index < SPRITE_COUNT) begin
          sprite_pattern[w.sprite_index * GLYPH_ROWS + w.pattern_row] = w.data;
          pattern_known[w.sprite_index * GLYPH_ROWS + w.pattern_row]  = 1'b1;
        end
      end
      CMD_RENDER: begin
        text_row   = w.line / GLYPH_ROWS;
        glyph_line = w.line[2:0];
        for (int c = 0; c < TEXT_COLUMNS; c++) begin
          if (text_row < TEXT_ROWS) begin
            row_bytes[c] = glyph_rom[{char_map[text_row * TEXT_COLUMNS + c], glyph_line}];
          end else begin
            row_bytes[c] = 8'h00;
          end
        end
        for (int s = 0; s < SPRITE_COUNT; s++) begin
          top = sprite_top[s];
          if (sprite_on[s] && w.line >= top && w.line < top + GLYPH_ROWS) begin
            pat = sprite_pattern[s * GLYPH_ROWS + (w.line - top)];
            cx  = sprite_left[s] / 8;
            sx  = sprite_left[s] % 8;
            if (cx < TEXT_COLUMNS) begin
              row_bytes[cx] = row_bytes[cx] | (pat >> sx);
            end
            // drop the spill past the right edge
            if (sx != 0 && cx + 1 < TEXT_COLUMNS) begin
              row_bytes[cx + 1] = row_bytes[cx + 1] | (pat << (8 - sx));
            end
          end
        end
        for (int c = 0; c < TEXT_COLUMNS; c++) begin
          want.pixel_byte = typed ? fill : row_bytes[c];
          want.column     = 5'(c);
          want.last       = (c == TEXT_COLUMNS - 1);
          pending_pixels.push_back(want);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_command(cmd_word_t w, logic typed, logic [7:0] fill);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.command       <= w.command;
    in_bus.address       <= w.address;
    in_bus.data          <= w.data;
    in_bus.sprite_index  <= w.sprite_index;
    in_bus.pattern_row   <= w.pattern_row;
    in_bus.sprite_x      <= w.sprite_x;
    in_bus.sprite_y      <= w.sprite_y;
    in_bus.sprite_enable <= w.sprite_enable;
    in_bus.line          <= w.line;
    do @(posedge clk); while (!in_bus.ready);
    predict_pixels(w, typed, fill);
  endtask

  always @(negedge clk) begin
    out_bus.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.pixel_byte = out_bus.pixel_byte;
      got.column     = out_bus.column;
      got.last       = out_bus.last;
      if (pending_pixels.size() == 0) begin
        $display("%0t: expected no word, got byte=%02h column=%0d last=%0b",
                 $time, got.pixel_byte, got.column, got.last);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_byte !== want.pixel_byte || got.column !== want.column ||
            got.last !== want.last) begin
          $display("%0t: expected byte=%02h column=%0d last=%0b,",
                   $time, want.pixel_byte, want.column, want.last,
                   " got byte=%02h column=%0d last=%0b",
                   got.pixel_byte, got.column, got.last);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    cmd_word_t w;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.command       = CMD_WR_CELL;
    in_bus.address       = '0;
    in_bus.data          = '0;
    in_bus.sprite_index  = '0;
    in_bus.pattern_row   = '0;
    in_bus.sprite_x      = '0;
    in_bus.sprite_y      = '0;
    in_bus.sprite_enable = 1'b0;
    in_bus.line          = '0;
    out_bus.ready        = 1'b0;
    for (int s = 0; s < SPRITE_COUNT; s++) begin
      sprite_left[s] = '0;
      sprite_top[s]  = '0;
      sprite_on[s]   = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Blank the glyphs in use, the top and bottom text rows and the first patterns
    for (int a = 0; a < GLYPH_CODES * GLYPH_ROWS; a++) begin
      w = noisy_word();
      w.command = CMD_WR_GLYPH;
      w.address = 11'(a);
      w.data    = 8'h00;
      send_command(w, 1'b0, 8'h00);
    end
    for (int a = 0; a < 2 * TEXT_COLUMNS; a++) begin
      w = noisy_word();
      w.command = CMD_WR_CELL;
      if (a < TEXT_COLUMNS) begin
        w.address = 11'(a);
      end else begin
        w.address = 11'((TEXT_ROWS - 1) * TEXT_COLUMNS + a - TEXT_COLUMNS);
      end
      w.data    = 8'h00;
      send_command(w, 1'b0, 8'h00);
    end
    for (int a = 0; a < READY_SPRITES * GLYPH_ROWS; a++) begin
      w = noisy_word();
      w.command      = CMD_WR_ROW;
      w.sprite_index = 4'(a / GLYPH_ROWS);
      w.pattern_row  = 3'(a % GLYPH_ROWS);
      w.data         = 8'h00;
      send_command(w, 1'b0, 8'h00);
    end

    //                         cmd             addr  data   idx prow x   y    en    line typed fill
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 0,   1'b1, 8'h00));
    script.push_back(plan_step(CMD_WR_GLYPH,   3,    8'hFF, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 3,   1'b1, 8'hFF));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 187, 1'b1, 8'hFF));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 255, 1'b1, 8'h00));
    script.push_back(plan_step(CMD_WR_CELL,    767,  8'hFF, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_CELL,    768,  8'h01, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_CELL,    2047, 8'hAA, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_GLYPH,   2047, 8'h81, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 191, 1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_CELL,    767,  8'h00, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ROW,     0,    8'hFF, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ATTR,    0,    8'h00, 0,  0, 0,   0,   1'b1, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ROW,     0,    8'hC3, 15, 7, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ATTR,    0,    8'h00, 15, 0, 252, 248, 1'b1, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 255, 1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ROW,     0,    8'h5A, 2,  2, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ATTR,    0,    8'h00, 2,  0, 13,  5,   1'b1, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 7,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ROW,     0,    8'hFF, 1,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ATTR,    0,    8'h00, 1,  0, 511, 0,   1'b1, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_WR_ATTR,    0,    8'h00, 0,  0, 0,   0,   1'b0, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_SPARE_LAST, 0,    8'hFF, 0,  0, 0,   0,   1'b1, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 0,   1'b1, 8'h00));
    script.push_back(plan_step(CMD_WR_ATTR,    0,    8'h00, 15, 0, 8,   250, 1'b1, 0,   1'b0, 8'h00));
    script.push_back(plan_step(CMD_RENDER,     0,    8'h00, 0,  0, 0,   0,   1'b0, 1,   1'b1, 8'h00));

    foreach (script[i]) begin
      send_command(script[i].word, script[i].typed, script[i].fill);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = (n >= CALM_FIRST && n < CALM_LAST);
      send_command(random_command(), 1'b0, 8'h00);
    end
    steady = 1'b0;

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // hold a while longer to catch stray words
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
